// File: rtl/core/gpx_pkg.sv
package gpx_pkg;

    localparam int unsigned PIN_COUNT  = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CMD_W      = 8;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;

    localparam logic [CMD_W-1:0] CMD_LAST = 8'd7;

    localparam logic [2:0] CMD_INPUT0    = 3'd0;
    localparam logic [2:0] CMD_INPUT1    = 3'd1;
    localparam logic [2:0] CMD_OUTPUT0   = 3'd2;
    localparam logic [2:0] CMD_OUTPUT1   = 3'd3;
    localparam logic [2:0] CMD_POLARITY0 = 3'd4;
    localparam logic [2:0] CMD_POLARITY1 = 3'd5;
    localparam logic [2:0] CMD_CONFIG0   = 3'd6;
    localparam logic [2:0] CMD_CONFIG1   = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIRTUAL_MASK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_OUTPUT = 2'd2;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

endpackage

// File: rtl/core/gpx_controller.sv
module gpx_controller (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output logic            done,
    output gpx_pkg::dp_cmd_t cmd
);
    import gpx_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.execute;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg == ST_EXEC);
    assign done = done_reg;

`ifndef SYNTHESIS
    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("An accepted transfer did not start execution.");

    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy && done)
        else $error("Execution did not finish in one cycle with a result strobe.");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("A result strobe appeared without a preceding execution.");
`endif

endmodule

// File: rtl/core/gpx_datapath.sv
module gpx_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  gpx_pkg::dp_cmd_t                      cmd,
    input  logic                                  cfg_we,
    input  logic [gpx_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [gpx_pkg::PIN_COUNT-1:0]         cfg_data,
    input  logic [gpx_pkg::MODE_W-1:0]            mode,
    input  logic [gpx_pkg::CMD_W-1:0]             reg_index,
    input  logic [gpx_pkg::BYTE_W-1:0]            write_data,
    input  logic [gpx_pkg::PIN_COUNT-1:0]         pin_levels,
    output logic [gpx_pkg::BYTE_W-1:0]            read_data,
    output logic                                  status,
    output logic [gpx_pkg::PIN_COUNT-1:0]         pin_drive,
    output logic                                  interrupt_line
);
    import gpx_pkg::*;

    logic [PIN_COUNT-1:0] dir_reg;
    logic [PIN_COUNT-1:0] virt_reg;

    logic [PIN_COUNT-1:0] latch_reg;
    logic [PIN_COUNT-1:0] latch_next;
    logic [PIN_COUNT-1:0] pol_reg;
    logic [PIN_COUNT-1:0] pol_next;
    logic [PIN_COUNT-1:0] prev_reg;
    logic                 int_reg;
    logic                 int_next;

    logic [MODE_W-1:0]    mode_reg;
    logic [CMD_W-1:0]     cmd_reg;
    logic [BYTE_W-1:0]    wdata_reg;
    logic [PIN_COUNT-1:0] pins_reg;

    logic [BYTE_W-1:0]    rdata_reg;
    logic [BYTE_W-1:0]    rdata_next;
    logic                 status_reg;
    logic                 status_next;
    logic [PIN_COUNT-1:0] drive_reg;

    logic [PIN_COUNT-1:0] edges;
    logic                 port;
    logic                 is_read;
    logic [BYTE_W-1:0]    latch_byte;
    logic [BYTE_W-1:0]    pol_byte;
    logic [BYTE_W-1:0]    virt_byte;
    logic [BYTE_W-1:0]    dir_byte;
    logic [BYTE_W-1:0]    pins_byte;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= mode;
            cmd_reg   <= reg_index;
            wdata_reg <= write_data;
            pins_reg  <= pin_levels;
        end
        if (cmd.execute)
        begin
            rdata_reg  <= rdata_next;
            status_reg <= status_next;
            drive_reg  <= latch_next & dir_reg & ~virt_reg;
        end
    end

    // The initial output value is only ever used to load the output latch.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg   <= '0;
            virt_reg  <= '0;
            latch_reg <= '0;
            pol_reg   <= '0;
            prev_reg  <= '0;
            int_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.execute)
            begin
                latch_reg <= latch_next;
                pol_reg   <= pol_next;
                prev_reg  <= pins_reg;
                int_reg   <= int_next;
            end
            else if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DIRECTION_MASK: dir_reg <= cfg_data;
                    CFG_VIRTUAL_MASK:   virt_reg <= cfg_data;
                    CFG_INITIAL_OUTPUT: latch_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign edges      = (pins_reg ^ prev_reg) & ~dir_reg & ~virt_reg;
    assign port       = cmd_reg[0];
    assign is_read    = (mode_reg == MODE_READ);
    assign latch_byte = port ? latch_reg[15:8] : latch_reg[7:0];
    assign pol_byte   = port ? pol_reg[15:8]   : pol_reg[7:0];
    assign virt_byte  = port ? virt_reg[15:8]  : virt_reg[7:0];
    assign dir_byte   = port ? dir_reg[15:8]   : dir_reg[7:0];
    assign pins_byte  = port ? pins_reg[15:8]  : pins_reg[7:0];

    always_comb
    begin
        latch_next  = latch_reg;
        pol_next    = pol_reg;
        int_next    = (edges != '0) ? 1'b0 : int_reg;
        rdata_next  = '0;
        status_next = STATUS_OK;
        if (mode_reg == MODE_READ || mode_reg == MODE_WRITE)
        begin
            if (cmd_reg > CMD_LAST)
            begin
                status_next = STATUS_INVALID;
            end
            else
            begin
                unique case (cmd_reg[2:0]) inside
                    CMD_INPUT0, CMD_INPUT1:
                    begin
                        if (is_read)
                        begin
                            rdata_next = ((latch_byte & virt_byte) | (pins_byte & ~virt_byte))
                                         ^ pol_byte;
                            int_next   = 1'b1;
                        end
                    end
                    CMD_OUTPUT0, CMD_OUTPUT1:
                    begin
                        if (is_read)
                            rdata_next = latch_byte;
                        else if (port)
                            latch_next = {wdata_reg, latch_reg[7:0]};
                        else
                            latch_next = {latch_reg[15:8], wdata_reg};
                    end
                    CMD_POLARITY0, CMD_POLARITY1:
                    begin
                        if (is_read)
                            rdata_next = pol_byte;
                        else if (port)
                            pol_next = {wdata_reg, pol_reg[7:0]};
                        else
                            pol_next = {pol_reg[15:8], wdata_reg};
                    end
                    CMD_CONFIG0, CMD_CONFIG1:
                    begin
                        if (is_read)
                            rdata_next = ~dir_byte;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign read_data      = rdata_reg;
    assign status         = status_reg;
    assign pin_drive      = drive_reg;
    assign interrupt_line = int_reg;

endmodule

// File: rtl/core/gpio_expander_register_file.sv
// A transfer is captured when start is seen in the idle state; in the execute state the result,
// status, pin drive and done are registered. No new transfer is accepted while busy (execute state);
// done is high for exactly one cycle and the receiver cannot stall it.
// Reset (rst_n, asynchronous, active low) clears all configuration registers, the output
// latch, polarity, previous pin levels and the interrupt state, and returns the controller to idle.
module gpio_expander_register_file (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [gpx_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [gpx_pkg::PIN_COUNT-1:0]         cfg_data,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [gpx_pkg::MODE_W-1:0]            mode,
    input  logic [gpx_pkg::CMD_W-1:0]             reg_index,
    input  logic [gpx_pkg::BYTE_W-1:0]            write_data,
    input  logic [gpx_pkg::PIN_COUNT-1:0]         pin_levels,
    output logic                                  done,
    output logic [gpx_pkg::BYTE_W-1:0]            read_data,
    output logic                                  status,
    output logic [gpx_pkg::PIN_COUNT-1:0]         pin_drive,
    output logic                                  interrupt_line
);
    import gpx_pkg::*;

    dp_cmd_t cmd;

    gpx_controller u_controller (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    gpx_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mode           (mode),
        .reg_index      (reg_index),
        .write_data     (write_data),
        .pin_levels     (pin_levels),
        .read_data      (read_data),
        .status         (status),
        .pin_drive      (pin_drive),
        .interrupt_line (interrupt_line)
    );

endmodule

// File: sim/testbench.sv
module testbench;
    import gpx_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned SETTING_COUNT = 8;
    localparam int unsigned ITEMS_PER_SETTING = 180;

    typedef struct {
        logic [BYTE_W-1:0]    rd;
        logic                 st;
        logic [PIN_COUNT-1:0] drive;
        logic                 irq;
    } gpx_reply_t;

    class expander_scoreboard;
        logic [PIN_COUNT-1:0] dir_mask;
        logic [PIN_COUNT-1:0] virt_mask;
        logic [PIN_COUNT-1:0] out_latch;
        logic [PIN_COUNT-1:0] pol_mask;
        logic [PIN_COUNT-1:0] last_pins;
        logic                 irq_state;
        gpx_reply_t           replies_due[$];
        int unsigned          mismatches;
        int unsigned          reads;
        int unsigned          writes;
        int unsigned          samples;
        int unsigned          invalid;

        function new();
            dir_mask   = '0;
            virt_mask  = '0;
            out_latch  = '0;
            pol_mask   = '0;
            last_pins  = '0;
            irq_state  = 1'b0;
            mismatches = 0;
            reads      = 0;
            writes     = 0;
            samples    = 0;
            invalid    = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [PIN_COUNT-1:0] value);
            case (idx)
                CFG_DIRECTION_MASK: dir_mask = value;
                CFG_VIRTUAL_MASK:   virt_mask = value;
                CFG_INITIAL_OUTPUT: out_latch = value;
                default: ;
            endcase
        endfunction

        function void note_transfer(logic [MODE_W-1:0] op, logic [CMD_W-1:0] cmd,
                                    logic [BYTE_W-1:0] wbyte, logic [PIN_COUNT-1:0] pins);
            gpx_reply_t        r;
            logic [PIN_COUNT-1:0] edges;
            logic [BYTE_W-1:0] phys;
            int unsigned       lo;
            r.rd = '0;
            r.st = STATUS_OK;
            edges = (pins ^ last_pins) & ~dir_mask & ~virt_mask;
            if (edges != '0)
                irq_state = 1'b0;
            last_pins = pins;
            lo = cmd[0] ? BYTE_W : 0;
            if (op == MODE_READ || op == MODE_WRITE) begin
                if (op == MODE_READ)
                    reads++;
                else
                    writes++;
                if (cmd > CMD_LAST) begin
                    r.st = STATUS_INVALID;
                    invalid++;
                end
                else begin
                    case (cmd[2:0])
                        CMD_INPUT0, CMD_INPUT1:
                            if (op == MODE_READ) begin
                                phys = ~virt_mask[lo +: BYTE_W];
                                r.rd = ((out_latch[lo +: BYTE_W] & ~phys)
                                        | (pins[lo +: BYTE_W] & phys))
                                       ^ pol_mask[lo +: BYTE_W];
                                irq_state = 1'b1;
                            end
                        CMD_OUTPUT0, CMD_OUTPUT1:
                            if (op == MODE_READ)
                                r.rd = out_latch[lo +: BYTE_W];
                            else
                                out_latch[lo +: BYTE_W] = wbyte;
                        CMD_POLARITY0, CMD_POLARITY1:
                            if (op == MODE_READ)
                                r.rd = pol_mask[lo +: BYTE_W];
                            else
                                pol_mask[lo +: BYTE_W] = wbyte;
                        default:
                            if (op == MODE_READ)
                                r.rd = ~dir_mask[lo +: BYTE_W];
                    endcase
                end
            end
            else
                samples++;
            r.drive = out_latch & dir_mask & ~virt_mask;
            r.irq = irq_state;
            replies_due.push_back(r);
        endfunction

        function void compare_reply(logic [BYTE_W-1:0] rd, logic st,
                                    logic [PIN_COUNT-1:0] drive, logic irq);
            gpx_reply_t e;
            if (replies_due.size() == 0) begin
                $display("%0t: result with none expected: read_data %h status %b pin_drive %h irq %b",
                         $time, rd, st, drive, irq);
                mismatches++;
                return;
            end
            e = replies_due.pop_front();
            if (rd !== e.rd) begin
                $display("%0t: read_data expected %h, got %h", $time, e.rd, rd);
                mismatches++;
            end
            if (st !== e.st) begin
                $display("%0t: status expected %b, got %b", $time, e.st, st);
                mismatches++;
            end
            if (drive !== e.drive) begin
                $display("%0t: pin_drive expected %h, got %h", $time, e.drive, drive);
                mismatches++;
            end
            if (irq !== e.irq) begin
                $display("%0t: interrupt_line expected %b, got %b", $time, e.irq, irq);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [PIN_COUNT-1:0]  cfg_data = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [MODE_W-1:0]     mode = '0;
    logic [CMD_W-1:0]      reg_index = '0;
    logic [BYTE_W-1:0]     write_data = '0;
    logic [PIN_COUNT-1:0]  pin_levels = '0;
    logic                  done;
    logic [BYTE_W-1:0]     read_data;
    logic                  status;
    logic [PIN_COUNT-1:0]  pin_drive;
    logic                  interrupt_line;

    expander_scoreboard    sb;
    int unsigned           cycles = 0;
    int unsigned           settings_used = 0;
    logic [PIN_COUNT-1:0]  drive_pins = '0;

    gpio_expander_register_file dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .reg_index      (reg_index),
        .write_data     (write_data),
        .pin_levels     (pin_levels),
        .done           (done),
        .read_data      (read_data),
        .status         (status),
        .pin_drive      (pin_drive),
        .interrupt_line (interrupt_line)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.compare_reply(read_data, status, pin_drive, interrupt_line);
    end

    task automatic transfer(logic [MODE_W-1:0] op, logic [CMD_W-1:0] cmd,
                            logic [BYTE_W-1:0] wbyte, logic [PIN_COUNT-1:0] pins);
        start      <= 1'b1;
        mode       <= op;
        reg_index  <= cmd;
        write_data <= wbyte;
        pin_levels <= pins;
        do
            @(posedge clk);
        while (busy);
        sb.note_transfer(op, cmd, wbyte, pins);
        drive_pins = pins;
    endtask

    task automatic pause(int unsigned n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.replies_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [PIN_COUNT-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_register(idx, value);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(logic [PIN_COUNT-1:0] dir, logic [PIN_COUNT-1:0] virt,
                                 logic [PIN_COUNT-1:0] init);
        drain();
        write_setting(CFG_DIRECTION_MASK, dir);
        write_setting(CFG_VIRTUAL_MASK, virt);
        write_setting(CFG_INITIAL_OUTPUT, init);
        settings_used++;
    endtask

    task automatic random_transfer();
        logic [MODE_W-1:0]    op;
        logic [CMD_W-1:0]     cmd;
        logic [PIN_COUNT-1:0] pins;
        int unsigned          pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            op  = MODE_W'($urandom_range(0, 1));
            cmd = CMD_W'($urandom_range(0, CMD_LAST));
        end
        else if (pick < 8)
        begin
            op  = MODE_W'($urandom_range(MODE_SAMPLE, MODE_SPARE));
            cmd = CMD_W'($urandom);
        end
        else
        begin
            op  = MODE_W'($urandom_range(0, 1));
            cmd = CMD_W'($urandom_range(CMD_LAST + 1, 255));
        end
        case ($urandom_range(0, 3))
            0: pins = PIN_COUNT'($urandom);
            1: pins = drive_pins ^ (PIN_COUNT'(1) << $urandom_range(0, PIN_COUNT - 1));
            default: pins = drive_pins;
        endcase
        transfer(op, cmd, BYTE_W'($urandom), pins);
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_setting(CFG_UNUSED, 16'hBEEF);
        apply_setting(16'h0F0F, 16'h3030, 16'hA5C3);
        transfer(MODE_READ,   CMD_W'(CMD_INPUT0),    8'h00, 16'hFFFF);
        transfer(MODE_READ,   CMD_W'(CMD_INPUT1),    8'h00, 16'hFFFF);
        transfer(MODE_WRITE,  CMD_W'(CMD_OUTPUT0),   8'hFF, 16'hFFFF);
        transfer(MODE_WRITE,  CMD_W'(CMD_OUTPUT1),   8'h00, 16'hFFFF);
        transfer(MODE_READ,   CMD_W'(CMD_OUTPUT0),   8'h00, 16'hFFFF);
        transfer(MODE_READ,   CMD_W'(CMD_OUTPUT1),   8'hFF, 16'hFFFF);
        transfer(MODE_WRITE,  CMD_W'(CMD_POLARITY0), 8'hFF, 16'hFFFF);
        transfer(MODE_WRITE,  CMD_W'(CMD_POLARITY1), 8'h5A, 16'hFFFF);
        transfer(MODE_READ,   CMD_W'(CMD_POLARITY0), 8'h00, 16'hFFFF);
        transfer(MODE_READ,   CMD_W'(CMD_POLARITY1), 8'h00, 16'hFFFF);
        transfer(MODE_READ,   CMD_W'(CMD_INPUT0),    8'h00, 16'h0000);
        transfer(MODE_READ,   CMD_W'(CMD_INPUT1),    8'h00, 16'h0000);
        transfer(MODE_WRITE,  CMD_W'(CMD_INPUT0),    8'h33, 16'h0000);
        transfer(MODE_WRITE,  CMD_W'(CMD_CONFIG1),   8'hFF, 16'h0000);
        transfer(MODE_READ,   CMD_W'(CMD_CONFIG0),   8'h00, 16'h0000);
        transfer(MODE_READ,   CMD_W'(CMD_CONFIG1),   8'h00, 16'h0000);
        transfer(MODE_READ,   CMD_W'(CMD_LAST + 1),  8'h00, 16'h0000);
        transfer(MODE_WRITE,  8'hFF,                 8'hFF, 16'h0000);
        transfer(MODE_READ,   8'h80,                 8'h00, 16'h0000);
        transfer(MODE_SAMPLE, CMD_W'(CMD_OUTPUT0),   8'hFF, 16'h1234);
        transfer(MODE_SPARE,  CMD_W'(CMD_OUTPUT1),   8'hFF, 16'h0000);
        transfer(MODE_SAMPLE, 8'hFF,                 8'h00, 16'h0000);
        transfer(MODE_READ,   CMD_W'(CMD_INPUT0),    8'h00, 16'hFFFF);
        transfer(MODE_READ,   CMD_W'(CMD_INPUT1),    8'h00, 16'h8001);

        for (int unsigned s = 0; s < SETTING_COUNT; s++)
        begin
            case (s)
                0: apply_setting(16'h0000, 16'h0000, 16'h0000);
                1: apply_setting(16'hFFFF, 16'h0000, 16'hFFFF);
                2: apply_setting(16'h0000, 16'hFFFF, PIN_COUNT'($urandom));
                3: apply_setting(16'hFFFF, 16'hFFFF, PIN_COUNT'($urandom));
                default: apply_setting(PIN_COUNT'($urandom), PIN_COUNT'($urandom),
                                       PIN_COUNT'($urandom));
            endcase
            for (int unsigned i = 0; i < ITEMS_PER_SETTING; i++)
            begin
                if (s + 1 < SETTING_COUNT && $urandom_range(0, 3) == 0)
                    pause($urandom_range(1, 8));
                random_transfer();
            end
        end

        drain();
        $display("Covered %0d reads, %0d writes and %0d pin samples under %0d settings,",
                 sb.reads, sb.writes, sb.samples, settings_used);
        $display("of which %0d used an invalid command; %0d results were left unanswered.",
                 sb.invalid, sb.replies_due.size());
        if (sb.mismatches == 0 && sb.replies_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// File: sim.f
rtl/core/gpx_pkg.sv
rtl/core/gpx_controller.sv
rtl/core/gpx_datapath.sv
rtl/core/gpio_expander_register_file.sv
sim/testbench.sv
